// ===== design/tcp_pkg.sv =====
// Shared package for the tree coordinator protocol unit.
// Holds message codes, internal operation codes and the queued word type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tcp_pkg;

    localparam int MAX_CHILDREN_DEF = 16;
    localparam logic [15:0] SLOT_WIN_RST = 16'd256;

    localparam logic [1:0] CMD_MSG  = 2'd0;
    localparam logic [1:0] CMD_KEEP = 2'd1;
    localparam logic [1:0] CMD_SLOT = 2'd2;
    localparam logic [1:0] CMD_JOIN = 2'd3;

    localparam logic [7:0] MSG_JOIN_REQ   = 8'd0;
    localparam logic [7:0] MSG_JOIN_ACC   = 8'd1;
    localparam logic [7:0] MSG_CHILD_ACK  = 8'd2;
    localparam logic [7:0] MSG_LEAVE      = 8'd3;
    localparam logic [7:0] MSG_PING       = 8'd4;
    localparam logic [7:0] MSG_PING_REPLY = 8'd5;
    localparam logic [7:0] MSG_CLK_REQ    = 8'd6;
    localparam logic [7:0] MSG_CLK_ANS    = 8'd7;
    localparam logic [7:0] MSG_CLK_SET    = 8'd8;
    localparam logic [7:0] MSG_SLOT_SET   = 8'd9;
    localparam logic [7:0] MSG_SLOT       = 8'd11;
    localparam logic [7:0] MSG_DATA       = 8'd12;

    localparam logic [7:0] ROOT_RANK = 8'd0;
    localparam logic [7:0] SKIP_RANK = 8'd1;

    // miss count, 2-bit two's complement
    localparam logic [1:0] MISS_NEW   = 2'b11;
    localparam logic [1:0] MISS_CLEAR = 2'b00;
    localparam logic [1:0] MISS_DROP  = 2'b01;

    localparam logic [3:0] OP_NONE   = 4'd0;
    localparam logic [3:0] OP_JACC   = 4'd1;
    localparam logic [3:0] OP_JREQ   = 4'd2;
    localparam logic [3:0] OP_ADD    = 4'd3;
    localparam logic [3:0] OP_LEAVE  = 4'd4;
    localparam logic [3:0] OP_PING   = 4'd5;
    localparam logic [3:0] OP_PREPLY = 4'd6;
    localparam logic [3:0] OP_CREQ   = 4'd7;
    localparam logic [3:0] OP_CSET   = 4'd8;
    localparam logic [3:0] OP_SSET   = 4'd9;
    localparam logic [3:0] OP_DATA   = 4'd10;
    localparam logic [3:0] OP_KEEP   = 4'd11;
    localparam logic [3:0] OP_STICK  = 4'd12;
    localparam logic [3:0] OP_JTICK  = 4'd13;

    typedef struct packed {
        logic [3:0]  op;
        logic [63:0] src;
        logic [31:0] now;
        logic [31:0] mclock;
        logic [31:0] slot_start;
        logic [31:0] slot_end;
        logic [7:0]  byte0;
        logic [7:0]  byte1;
    } item_t;

endpackage

`default_nettype wire

// ===== design/tcp_front.sv =====
// Front part: accepts input words, classifies them into operations and
// queues them (two entries) for the back part. Depends on tcp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcp_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic [1:0]    s_command,
    input  wire logic [7:0]    s_msg_type,
    input  wire logic [7:0]    s_msg_rank,
    input  wire logic [63:0]   s_src_addr,
    input  wire logic [31:0]   s_msg_clock,
    input  wire logic [31:0]   s_msg_slot_start,
    input  wire logic [31:0]   s_msg_slot_end,
    input  wire logic [7:0]    s_msg_byte0,
    input  wire logic [7:0]    s_msg_byte1,
    input  wire logic [31:0]   s_now,
    output logic               q_valid,
    input  wire logic          q_ready,
    output tcp_pkg::item_t     q_item
);

    tcp_pkg::item_t fifo_reg [2];
    tcp_pkg::item_t item_in;
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     cnt_reg, cnt_next;
    logic           push, pop;
    logic [3:0]     op;

    always_comb begin
        op = tcp_pkg::OP_NONE;
        case (s_command)
            tcp_pkg::CMD_MSG: begin
                case (s_msg_type)
                    tcp_pkg::MSG_JOIN_ACC: begin
                        if (s_msg_rank == tcp_pkg::ROOT_RANK) begin
                            op = tcp_pkg::OP_JACC;
                        end
                    end
                    tcp_pkg::MSG_JOIN_REQ: begin
                        if (s_msg_rank != tcp_pkg::SKIP_RANK) begin
                            op = tcp_pkg::OP_JREQ;
                        end
                    end
                    tcp_pkg::MSG_CHILD_ACK:  op = tcp_pkg::OP_ADD;
                    tcp_pkg::MSG_LEAVE:      op = tcp_pkg::OP_LEAVE;
                    tcp_pkg::MSG_PING:       op = tcp_pkg::OP_PING;
                    tcp_pkg::MSG_PING_REPLY: op = tcp_pkg::OP_PREPLY;
                    tcp_pkg::MSG_CLK_REQ:    op = tcp_pkg::OP_CREQ;
                    tcp_pkg::MSG_CLK_SET:    op = tcp_pkg::OP_CSET;
                    tcp_pkg::MSG_SLOT_SET:   op = tcp_pkg::OP_SSET;
                    tcp_pkg::MSG_DATA:       op = tcp_pkg::OP_DATA;
                    default:                 op = tcp_pkg::OP_NONE;
                endcase
            end
            tcp_pkg::CMD_KEEP: op = tcp_pkg::OP_KEEP;
            tcp_pkg::CMD_SLOT: op = tcp_pkg::OP_STICK;
            tcp_pkg::CMD_JOIN: op = tcp_pkg::OP_JTICK;
            default:           op = tcp_pkg::OP_NONE;
        endcase
    end

    always_comb begin
        item_in.op         = op;
        item_in.src        = s_src_addr;
        item_in.now        = s_now;
        item_in.mclock     = s_msg_clock;
        item_in.slot_start = s_msg_slot_start;
        item_in.slot_end   = s_msg_slot_end;
        item_in.byte0      = s_msg_byte0;
        item_in.byte1      = s_msg_byte1;
    end

    assign s_ready = (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = fifo_reg[rd_ptr_reg];
    assign push    = s_valid & s_ready;
    assign pop     = q_valid & q_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

`default_nettype wire

// ===== design/tcp_back.sv =====
// Back part: executes queued operations, owns node state, the child table
// memory and the result register. Depends on tcp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcp_back #(
    parameter int MAX_CHILDREN = tcp_pkg::MAX_CHILDREN_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cfg_we,
    input  wire logic [15:0]   cfg_wdata,
    input  wire logic          q_valid,
    output logic               q_ready,
    input  wire tcp_pkg::item_t q_item,
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic               m_broadcast,
    output logic [63:0]        m_dest_addr,
    output logic [7:0]         m_out_type,
    output logic [31:0]        m_out_clock,
    output logic [31:0]        m_out_slot_start,
    output logic [31:0]        m_out_slot_end,
    output logic [7:0]         m_out_byte0,
    output logic [7:0]         m_out_byte1,
    output logic               m_last
);

    localparam int IDX_W = (MAX_CHILDREN > 1) ? $clog2(MAX_CHILDREN) : 1;
    localparam int CNT_W = $clog2(MAX_CHILDREN + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_CHILDREN);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EXEC  = 3'd1;
    localparam logic [2:0] ST_WRD   = 3'd2;
    localparam logic [2:0] ST_WPROC = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]       state_reg, state_next;
    tcp_pkg::item_t   cur_reg, cur_next;
    logic             joined_reg, joined_next;
    logic [63:0]      parent_reg, parent_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [31:0]      offset_reg, offset_next;
    logic [31:0]      sclk_reg, sclk_next;
    logic [31:0]      sstart_reg, sstart_next;
    logic [31:0]      send_reg, send_next;
    logic [7:0]       b0_reg, b0_next;
    logic [7:0]       b1_reg, b1_next;
    logic [15:0]      window_reg;
    logic [CNT_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] wr_reg, wr_next;
    logic             found_reg, found_next;
    logic             pend_valid_reg, pend_valid_next;
    logic             pend_bcast_reg, pend_bcast_next;
    logic [63:0]      pend_dest_reg, pend_dest_next;
    logic [7:0]       pend_type_reg, pend_type_next;
    logic             m_valid_reg, m_valid_next;

    logic [63:0]      addr_mem [MAX_CHILDREN];
    logic [1:0]       miss_mem [MAX_CHILDREN];
    logic [63:0]      rd_addr_q;
    logic [1:0]       rd_miss_q;
    logic             mem_we;
    logic [IDX_W-1:0] mem_wa;
    logic [63:0]      mem_wd_addr;
    logic [1:0]       mem_wd_miss;

    logic             load_out, load_last;
    logic             out_free;
    logic [31:0]      t_now;
    logic             hit;

    assign out_free = ~m_valid_reg | m_ready;
    assign t_now    = cur_reg.now + offset_reg;
    assign hit      = (rd_addr_q == cur_reg.src);
    assign m_valid  = m_valid_reg;

    always_comb begin
        logic        keep, emit, advance;
        logic [1:0]  nmiss;
        logic [7:0]  etype;

        state_next      = state_reg;
        cur_next        = cur_reg;
        joined_next     = joined_reg;
        parent_next     = parent_reg;
        count_next      = count_reg;
        offset_next     = offset_reg;
        sclk_next       = sclk_reg;
        sstart_next     = sstart_reg;
        send_next       = send_reg;
        b0_next         = b0_reg;
        b1_next         = b1_reg;
        rd_next         = rd_reg;
        wr_next         = wr_reg;
        found_next      = found_reg;
        pend_valid_next = pend_valid_reg;
        pend_bcast_next = pend_bcast_reg;
        pend_dest_next  = pend_dest_reg;
        pend_type_next  = pend_type_reg;
        q_ready         = 1'b0;
        mem_we          = 1'b0;
        mem_wa          = wr_reg[IDX_W-1:0];
        mem_wd_addr     = rd_addr_q;
        mem_wd_miss     = rd_miss_q;
        load_out        = 1'b0;
        load_last       = 1'b0;
        keep            = 1'b1;
        emit            = 1'b0;
        advance         = 1'b1;
        nmiss           = rd_miss_q;
        etype           = tcp_pkg::MSG_SLOT;

        case (state_reg)
            ST_IDLE: begin
                q_ready = 1'b1;
                if (q_valid) begin
                    cur_next   = q_item;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_DONE;
                rd_next    = '0;
                wr_next    = '0;
                found_next = 1'b0;
                pend_bcast_next = 1'b0;
                pend_dest_next  = cur_reg.src;
                case (cur_reg.op)
                    tcp_pkg::OP_JACC: begin
                        if (!joined_reg) begin
                            joined_next     = 1'b1;
                            parent_next     = cur_reg.src;
                            pend_valid_next = 1'b1;
                            pend_type_next  = tcp_pkg::MSG_CHILD_ACK;
                        end
                    end
                    tcp_pkg::OP_JREQ: begin
                        if (joined_reg) begin
                            pend_valid_next = 1'b1;
                            pend_type_next  = tcp_pkg::MSG_JOIN_ACC;
                        end
                    end
                    tcp_pkg::OP_ADD: begin
                        if (joined_reg && count_reg < MAX_CNT) begin
                            mem_we      = 1'b1;
                            mem_wa      = count_reg[IDX_W-1:0];
                            mem_wd_addr = cur_reg.src;
                            mem_wd_miss = tcp_pkg::MISS_NEW;
                            count_next  = count_reg + 1'b1;
                        end
                    end
                    tcp_pkg::OP_LEAVE, tcp_pkg::OP_PREPLY: begin
                        if (joined_reg) begin
                            state_next = ST_WRD;
                        end
                    end
                    tcp_pkg::OP_PING: begin
                        if (joined_reg) begin
                            pend_valid_next = 1'b1;
                            pend_type_next  = tcp_pkg::MSG_PING_REPLY;
                        end
                    end
                    tcp_pkg::OP_CREQ: begin
                        if (joined_reg) begin
                            sclk_next       = t_now;
                            pend_valid_next = 1'b1;
                            pend_type_next  = tcp_pkg::MSG_CLK_ANS;
                        end
                    end
                    tcp_pkg::OP_CSET: begin
                        if (joined_reg) begin
                            offset_next = cur_reg.mclock - cur_reg.now;
                        end
                    end
                    tcp_pkg::OP_SSET: begin
                        if (joined_reg) begin
                            sstart_next = cur_reg.slot_start;
                            send_next   = cur_reg.slot_end;
                        end
                    end
                    tcp_pkg::OP_DATA: begin
                        if (joined_reg) begin
                            b0_next         = cur_reg.byte0;
                            b1_next         = cur_reg.byte1;
                            pend_valid_next = 1'b1;
                            pend_dest_next  = parent_reg;
                            pend_type_next  = tcp_pkg::MSG_DATA;
                        end
                    end
                    tcp_pkg::OP_KEEP: begin
                        state_next = ST_WRD;
                    end
                    tcp_pkg::OP_STICK: begin
                        if (send_reg != 32'd0) begin
                            if (t_now > sstart_reg && t_now < send_reg) begin
                                state_next = ST_WRD;
                            end else if (t_now > send_reg) begin
                                sstart_next = sstart_reg + {16'd0, window_reg};
                                send_next   = send_reg + {16'd0, window_reg};
                            end
                        end
                    end
                    tcp_pkg::OP_JTICK: begin
                        if (!joined_reg) begin
                            pend_valid_next = 1'b1;
                            pend_bcast_next = 1'b1;
                            pend_dest_next  = 64'd0;
                            pend_type_next  = tcp_pkg::MSG_JOIN_REQ;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_WRD: begin
                if (rd_reg == count_reg) begin
                    count_next = wr_reg;
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_WPROC;
                end
            end
            ST_WPROC: begin
                case (cur_reg.op)
                    tcp_pkg::OP_KEEP: begin
                        if (rd_miss_q == tcp_pkg::MISS_DROP) begin
                            keep = 1'b0;
                        end else begin
                            emit  = 1'b1;
                            etype = tcp_pkg::MSG_PING;
                            nmiss = rd_miss_q + 2'd1;
                        end
                    end
                    tcp_pkg::OP_LEAVE: begin
                        if (!found_reg && hit) begin
                            found_next = 1'b1;
                            keep       = 1'b0;
                        end
                    end
                    tcp_pkg::OP_PREPLY: begin
                        if (!found_reg && hit) begin
                            found_next = 1'b1;
                            nmiss      = tcp_pkg::MISS_CLEAR;
                        end
                    end
                    tcp_pkg::OP_STICK: begin
                        emit  = 1'b1;
                        etype = tcp_pkg::MSG_SLOT;
                    end
                    default: begin
                    end
                endcase
                if (emit && pend_valid_reg && !out_free) begin
                    advance    = 1'b0;
                    found_next = found_reg;
                end
                if (advance) begin
                    if (emit) begin
                        if (pend_valid_reg) begin
                            load_out = 1'b1;
                        end
                        pend_valid_next = 1'b1;
                        pend_bcast_next = 1'b0;
                        pend_dest_next  = rd_addr_q;
                        pend_type_next  = etype;
                    end
                    if (keep) begin
                        mem_we      = 1'b1;
                        mem_wd_miss = nmiss;
                        wr_next     = wr_reg + 1'b1;
                    end
                    rd_next    = rd_reg + 1'b1;
                    state_next = ST_WRD;
                end
            end
            ST_DONE: begin
                if (!pend_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    load_out        = 1'b1;
                    load_last       = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        m_valid_next = load_out | (m_valid_reg & ~m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            joined_reg     <= 1'b0;
            parent_reg     <= 64'd0;
            count_reg      <= '0;
            offset_reg     <= 32'd0;
            sclk_reg       <= 32'd0;
            sstart_reg     <= 32'd0;
            send_reg       <= 32'd0;
            b0_reg         <= 8'd0;
            b1_reg         <= 8'd0;
            window_reg     <= tcp_pkg::SLOT_WIN_RST;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            joined_reg     <= joined_next;
            parent_reg     <= parent_next;
            count_reg      <= count_next;
            offset_reg     <= offset_next;
            sclk_reg       <= sclk_next;
            sstart_reg     <= sstart_next;
            send_reg       <= send_next;
            b0_reg         <= b0_next;
            b1_reg         <= b1_next;
            if (cfg_we) begin
                window_reg <= cfg_wdata;
            end
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg        <= cur_next;
        rd_reg         <= rd_next;
        wr_reg         <= wr_next;
        found_reg      <= found_next;
        pend_bcast_reg <= pend_bcast_next;
        pend_dest_reg  <= pend_dest_next;
        pend_type_reg  <= pend_type_next;
        if (load_out) begin
            m_broadcast      <= pend_bcast_reg;
            m_dest_addr      <= pend_dest_reg;
            m_out_type       <= pend_type_reg;
            m_out_clock      <= sclk_reg;
            m_out_slot_start <= sstart_reg;
            m_out_slot_end   <= send_reg;
            m_out_byte0      <= b0_reg;
            m_out_byte1      <= b1_reg;
            m_last           <= load_last;
        end
    end

    // child table: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            addr_mem[mem_wa] <= mem_wd_addr;
            miss_mem[mem_wa] <= mem_wd_miss;
        end
        rd_addr_q <= addr_mem[rd_reg[IDX_W-1:0]];
        rd_miss_q <= miss_mem[rd_reg[IDX_W-1:0]];
    end

endmodule

`default_nettype wire

// ===== design/tree_coordinator_protocol_unit.sv =====
// Top level of the tree coordinator protocol unit.
// Instantiates tcp_front (accept, classify, queue) and tcp_back (execute).
//
//   channel   direction   handshake         payload
//   s_*       in          s_valid/s_ready   command, message fields, now
//   m_*       out         m_valid/m_ready   one send word per handshake, m_last
//   cfg_*     in          cfg_we            cfg_wdata = slot window
//
// An item without a table walk passes through the back part as accept,
// execute and, if a word is pending, send; a walk (keepalive, leave, ping
// reply, slot send) reads each child in ST_WRD, then ST_WPROC, paced by the
// registered read of the child table. A low m_ready stalls the walk and the
// last send. Reset is synchronous, active low; there is no clearing pass.
// A two-word queue lets the front accept while the back stalls on m_ready.
`timescale 1ns / 1ps
`default_nettype none

module tree_coordinator_protocol_unit #(
    parameter int MAX_CHILDREN = tcp_pkg::MAX_CHILDREN_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cfg_we,
    input  wire logic [15:0]   cfg_wdata,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic [1:0]    s_command,
    input  wire logic [7:0]    s_msg_type,
    input  wire logic [7:0]    s_msg_rank,
    input  wire logic [63:0]   s_src_addr,
    input  wire logic [31:0]   s_msg_clock,
    input  wire logic [31:0]   s_msg_slot_start,
    input  wire logic [31:0]   s_msg_slot_end,
    input  wire logic [7:0]    s_msg_byte0,
    input  wire logic [7:0]    s_msg_byte1,
    input  wire logic [31:0]   s_now,
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic               m_broadcast,
    output logic [63:0]        m_dest_addr,
    output logic [7:0]         m_out_type,
    output logic [31:0]        m_out_clock,
    output logic [31:0]        m_out_slot_start,
    output logic [31:0]        m_out_slot_end,
    output logic [7:0]         m_out_byte0,
    output logic [7:0]         m_out_byte1,
    output logic               m_last
);

    logic           q_valid;
    logic           q_ready;
    tcp_pkg::item_t q_item;

    tcp_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_msg_type       (s_msg_type),
        .s_msg_rank       (s_msg_rank),
        .s_src_addr       (s_src_addr),
        .s_msg_clock      (s_msg_clock),
        .s_msg_slot_start (s_msg_slot_start),
        .s_msg_slot_end   (s_msg_slot_end),
        .s_msg_byte0      (s_msg_byte0),
        .s_msg_byte1      (s_msg_byte1),
        .s_now            (s_now),
        .q_valid          (q_valid),
        .q_ready          (q_ready),
        .q_item           (q_item)
    );

    tcp_back #(
        .MAX_CHILDREN (MAX_CHILDREN)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .q_valid          (q_valid),
        .q_ready          (q_ready),
        .q_item           (q_item),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_broadcast      (m_broadcast),
        .m_dest_addr      (m_dest_addr),
        .m_out_type       (m_out_type),
        .m_out_clock      (m_out_clock),
        .m_out_slot_start (m_out_slot_start),
        .m_out_slot_end   (m_out_slot_end),
        .m_out_byte0      (m_out_byte0),
        .m_out_byte1      (m_out_byte1),
        .m_last           (m_last)
    );

endmodule

`default_nettype wire
